// ----- hdl/mpsp_pkg.sv -----
// Shared types, constants and the saturating helper function for the multi-page shelf packer.
`timescale 1ns / 1ps
package mpsp_pkg;

    localparam int MAX_PAGES  = 8;
    localparam int COORD_BITS = 13;
    localparam int PAGE_BITS  = $clog2(MAX_PAGES);
    localparam int OPEN_BITS  = PAGE_BITS + 1;
    localparam int SUM_BITS   = COORD_BITS + 2;
    localparam int POS_BITS   = 12;
    localparam int PNUM_BITS  = 3;
    localparam int LIMIT_BITS = 4;

    localparam logic [COORD_BITS-1:0] PAD       = COORD_BITS'(1);
    localparam logic [COORD_BITS-1:0] MIN_PAGE  = COORD_BITS'(64);
    localparam logic [COORD_BITS-1:0] MAX_PAGE  = COORD_BITS'(4096);
    localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

    localparam logic REG_PAGE_SIZE = 1'b0;
    localparam logic REG_MAX_PAGES = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_FRESH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [COORD_BITS-1:0] cursor_x;
        logic [COORD_BITS-1:0] cursor_y;
        logic [COORD_BITS-1:0] row_height;
    } t_shelf;

    typedef struct packed {
        logic                  fit;
        t_shelf                wb;
        logic [POS_BITS-1:0]   pos_x;
        logic [POS_BITS-1:0]   pos_y;
    } t_fit;

    typedef struct packed {
        logic                  placed;
        logic [PNUM_BITS-1:0]  page_number;
        logic [POS_BITS-1:0]   pos_x;
        logic [POS_BITS-1:0]   pos_y;
    } t_result;

    localparam t_shelf SHELF_RESET = '{cursor_x: PAD, cursor_y: PAD, row_height: '0};

    function automatic logic [COORD_BITS-1:0] sat_coord(input logic [SUM_BITS-1:0] v);
        logic [COORD_BITS-1:0] r;
        begin
            if (v > SUM_BITS'(COORD_MAX)) begin
                r = COORD_MAX;
            end else begin
                r = v[COORD_BITS-1:0];
            end
            return r;
        end
    endfunction

endpackage

// ----- hdl/multi_page_shelf_packer.sv -----
// Top level of the multi-page shelf packer: sequencer, configuration and result register.
//
//   Channel   Direction  Handshake                   Payload
//   in        into block i_in_valid / o_in_stall     i_rect_width, i_rect_height
//   out       from block o_out_valid / i_out_stall   o_placed, o_page_number, o_pos_x, o_pos_y
//   config    into block psel, penable, pwrite       paddr, pwdata, prdata
//
// A request that is not refused visits the open pages in order, one per cycle through the
// shelf memory read port, and opens a fresh page when none fits and the limit allows. The
// input is stalled while a request is in work. Reset is synchronous and leaves page 0 open
// with fresh cursors. A stalled result holds the output register; the next request is
// still taken and waits at its end.
`timescale 1ns / 1ps
module multi_page_shelf_packer
    import mpsp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [COORD_BITS-1:0] i_rect_width,
    input  logic [COORD_BITS-1:0] i_rect_height,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_placed,
    output logic [PNUM_BITS-1:0]  o_page_number,
    output logic [POS_BITS-1:0]   o_pos_x,
    output logic [POS_BITS-1:0]   o_pos_y,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    t_state                 r_state, n_state;
    logic [COORD_BITS-1:0]  r_page_size;
    logic [LIMIT_BITS-1:0]  r_max_pages;
    logic [COORD_BITS-1:0]  r_w, r_h;
    logic [PAGE_BITS-1:0]   r_page, n_page;
    logic [OPEN_BITS-1:0]   r_open_pages, n_open_pages;
    t_result                r_res, n_res;
    t_result                r_out;
    logic                   r_out_valid;

    logic [COORD_BITS-1:0]  ps;
    logic [OPEN_BITS-1:0]   limit;
    logic                   refuse;
    logic                   last_page;
    logic                   can_open;
    logic                   out_free;
    logic                   in_take;

    logic [PAGE_BITS-1:0]   rd_addr;
    t_shelf                 rd_data;
    logic                   wr_en;
    logic [PAGE_BITS-1:0]   wr_addr;
    t_shelf                 wr_data;
    t_fit                   fit;
    t_shelf                 fresh;

    mpsp_page_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    mpsp_fit u_fit (
        .i_entry     (rd_data),
        .i_width     (r_w),
        .i_height    (r_h),
        .i_page_size (ps),
        .o_fit       (fit)
    );

    assign pready = 1'b1;

    always_comb begin
        case (paddr[2])
            REG_PAGE_SIZE: prdata = 32'(r_page_size);
            REG_MAX_PAGES: prdata = 32'(r_max_pages);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_size <= COORD_BITS'(1024);
            r_max_pages <= LIMIT_BITS'(8);
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                REG_PAGE_SIZE: r_page_size <= pwdata[COORD_BITS-1:0];
                REG_MAX_PAGES: r_max_pages <= pwdata[LIMIT_BITS-1:0];
                default:       r_page_size <= r_page_size;
            endcase
        end
    end

    always_comb begin
        if (r_page_size < MIN_PAGE) begin
            ps = MIN_PAGE;
        end else if (r_page_size > MAX_PAGE) begin
            ps = MAX_PAGE;
        end else begin
            ps = r_page_size;
        end
        if (r_max_pages == '0) begin
            limit = OPEN_BITS'(1);
        end else if (32'(r_max_pages) > MAX_PAGES) begin
            limit = OPEN_BITS'(MAX_PAGES);
        end else begin
            limit = OPEN_BITS'(r_max_pages);
        end
    end

    assign refuse    = (SUM_BITS'(r_w) + SUM_BITS'(2) > SUM_BITS'(ps))
                    || (SUM_BITS'(r_h) + SUM_BITS'(2) > SUM_BITS'(ps));
    assign last_page = (OPEN_BITS'(r_page) + OPEN_BITS'(1)) >= r_open_pages;
    assign can_open  = (r_open_pages < limit) && (r_open_pages < OPEN_BITS'(MAX_PAGES));
    assign out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_take   = i_in_valid && !o_in_stall;

    always_comb begin
        fresh.cursor_x   = sat_coord(SUM_BITS'(PAD) + SUM_BITS'(r_w) + SUM_BITS'(PAD));
        fresh.cursor_y   = PAD;
        fresh.row_height = r_h;
    end

    always_comb begin
        n_state      = r_state;
        n_page       = r_page;
        n_open_pages = r_open_pages;
        n_res        = r_res;
        rd_addr      = r_page + PAGE_BITS'(1);
        wr_en        = 1'b0;
        wr_addr      = r_page;
        wr_data      = fit.wb;
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                rd_addr = '0;
                n_page  = '0;
                n_res   = '0;
                if (refuse) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                wr_en = 1'b1;
                if (fit.fit) begin
                    n_res.placed      = 1'b1;
                    n_res.page_number = PNUM_BITS'(r_page);
                    n_res.pos_x       = fit.pos_x;
                    n_res.pos_y       = fit.pos_y;
                    n_state           = ST_DONE;
                end else if (last_page) begin
                    n_state = can_open ? ST_FRESH : ST_DONE;
                end else begin
                    n_page = r_page + PAGE_BITS'(1);
                end
            end
            ST_FRESH: begin
                wr_en             = 1'b1;
                wr_addr           = r_open_pages[PAGE_BITS-1:0];
                wr_data           = fresh;
                n_open_pages      = r_open_pages + OPEN_BITS'(1);
                n_res.placed      = 1'b1;
                n_res.page_number = PNUM_BITS'(r_open_pages[PAGE_BITS-1:0]);
                n_res.pos_x       = PAD[POS_BITS-1:0];
                n_res.pos_y       = PAD[POS_BITS-1:0];
                n_state           = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_open_pages <= OPEN_BITS'(1);
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_open_pages <= n_open_pages;
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_page <= n_page;
        r_res  <= n_res;
        if (in_take) begin
            r_w <= i_rect_width;
            r_h <= i_rect_height;
        end
        if (r_state == ST_DONE && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_placed      = r_out.placed;
    assign o_page_number = r_out.page_number;
    assign o_pos_x       = r_out.pos_x;
    assign o_pos_y       = r_out.pos_y;

    a_open_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open_pages != '0 && r_open_pages <= OPEN_BITS'(MAX_PAGES))
        else $error("Open page count out of range.");

    a_page_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_placed |-> (OPEN_BITS'(o_page_number) < r_open_pages))
        else $error("Result names a page that is not open.");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_placed |-> (o_page_number == '0 && o_pos_x == '0 && o_pos_y == '0))
        else $error("Refused result carries a non-zero position.");

    a_one_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_FRESH |=> r_open_pages == $past(r_open_pages))
        else $error("Page count changed outside the page opening step.");

endmodule

// ----- hdl/mpsp_page_mem.sv -----
// Shelf state memory: one entry per page, registered read, valid bits per entry.
`timescale 1ns / 1ps
module mpsp_page_mem
    import mpsp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [PAGE_BITS-1:0] i_rd_addr,
    output t_shelf               o_rd_data,
    input  logic                 i_wr_en,
    input  logic [PAGE_BITS-1:0] i_wr_addr,
    input  t_shelf               i_wr_data
);

    t_shelf                 r_mem [MAX_PAGES];
    logic [MAX_PAGES-1:0]   r_vld;
    t_shelf                 r_rd_data;
    logic                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[i_rd_addr];
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : SHELF_RESET;

endmodule

// ----- hdl/mpsp_fit.sv -----
// Page evaluator: row wrap, height check and cursor advance for one page entry.
`timescale 1ns / 1ps
module mpsp_fit
    import mpsp_pkg::*;
(
    input  t_shelf                i_entry,
    input  logic [COORD_BITS-1:0] i_width,
    input  logic [COORD_BITS-1:0] i_height,
    input  logic [COORD_BITS-1:0] i_page_size,
    output t_fit                  o_fit
);

    logic [SUM_BITS-1:0] x_end;
    logic                wrap;
    t_shelf              wrapped;
    logic [SUM_BITS-1:0] y_end;
    logic [SUM_BITS-1:0] x_next;

    always_comb begin
        x_end = SUM_BITS'(i_entry.cursor_x) + SUM_BITS'(i_width) + SUM_BITS'(PAD);
        wrap  = x_end > SUM_BITS'(i_page_size);
        wrapped = i_entry;
        if (wrap) begin
            wrapped.cursor_x   = PAD;
            wrapped.cursor_y   = sat_coord(SUM_BITS'(i_entry.cursor_y)
                                 + SUM_BITS'(i_entry.row_height) + SUM_BITS'(PAD));
            wrapped.row_height = '0;
        end
        y_end  = SUM_BITS'(wrapped.cursor_y) + SUM_BITS'(i_height) + SUM_BITS'(PAD);
        x_next = SUM_BITS'(wrapped.cursor_x) + SUM_BITS'(i_width) + SUM_BITS'(PAD);

        o_fit.fit   = !(y_end > SUM_BITS'(i_page_size));
        o_fit.pos_x = wrapped.cursor_x[POS_BITS-1:0];
        o_fit.pos_y = wrapped.cursor_y[POS_BITS-1:0];
        o_fit.wb    = wrapped;
        if (o_fit.fit) begin
            o_fit.wb.cursor_x = sat_coord(x_next);
            if (i_height > wrapped.row_height) begin
                o_fit.wb.row_height = i_height;
            end
        end
    end

endmodule

// ----- tb/placement_checker.sv -----
// Checker for the shelf packer: predicts each placement and compares it with the block's result.
`timescale 1ns / 1ps
module placement_checker
    import mpsp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [COORD_BITS-1:0] i_rect_width,
    input  logic [COORD_BITS-1:0] i_rect_height,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic                  i_placed,
    input  logic [PNUM_BITS-1:0]  i_page_number,
    input  logic [POS_BITS-1:0]   i_pos_x,
    input  logic [POS_BITS-1:0]   i_pos_y,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [2:0]            i_paddr,
    input  logic [31:0]           i_pwdata,
    output int                    o_pending,
    output int                    o_mismatches
);

    logic [COORD_BITS-1:0] side_reg;
    logic [LIMIT_BITS-1:0] limit_reg;
    logic [COORD_BITS-1:0] cur_x [MAX_PAGES];
    logic [COORD_BITS-1:0] cur_y [MAX_PAGES];
    logic [COORD_BITS-1:0] row_h [MAX_PAGES];
    int                    pages_open;
    t_result               placements_due [$];

    function automatic logic [COORD_BITS-1:0] clip_coord(input int v);
        return (v > int'(COORD_MAX)) ? COORD_MAX : COORD_BITS'(v);
    endfunction

    function automatic t_result take_slot(input int p, input int w, input int h);
        t_result r;
        r.placed      = 1'b1;
        r.page_number = PNUM_BITS'(p);
        r.pos_x       = cur_x[p][POS_BITS-1:0];
        r.pos_y       = cur_y[p][POS_BITS-1:0];
        cur_x[p] = clip_coord(int'(cur_x[p]) + w + int'(PAD));
        if (h > int'(row_h[p])) begin
            row_h[p] = clip_coord(h);
        end
        return r;
    endfunction

    function automatic t_result pack_rect(input int w, input int h);
        t_result r;
        int      side;
        int      limit;
        r    = '0;
        side = int'(side_reg);
        if (side < int'(MIN_PAGE)) side = int'(MIN_PAGE);
        if (side > int'(MAX_PAGE)) side = int'(MAX_PAGE);
        limit = int'(limit_reg);
        if (limit == 0) limit = 1;
        if (limit > MAX_PAGES) limit = MAX_PAGES;
        if (w + 2 * int'(PAD) > side || h + 2 * int'(PAD) > side) begin
            return r;
        end
        for (int p = 0; p < pages_open; p++) begin
            // The row wrap sticks even when the page is then passed over for height.
            if (int'(cur_x[p]) + w + int'(PAD) > side) begin
                cur_x[p] = PAD;
                cur_y[p] = clip_coord(int'(cur_y[p]) + int'(row_h[p]) + int'(PAD));
                row_h[p] = '0;
            end
            if (int'(cur_y[p]) + h + int'(PAD) <= side) begin
                return take_slot(p, w, h);
            end
        end
        if (pages_open >= limit) begin
            return r;
        end
        cur_x[pages_open] = PAD;
        cur_y[pages_open] = PAD;
        row_h[pages_open] = '0;
        pages_open++;
        return take_slot(pages_open - 1, w, h);
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        int      errs;
        errs = 0;
        if (!i_rst_n) begin
            side_reg  = 13'd1024;
            limit_reg = 4'd8;
            for (int p = 0; p < MAX_PAGES; p++) begin
                cur_x[p] = PAD;
                cur_y[p] = PAD;
                row_h[p] = '0;
            end
            pages_open = 1;
            placements_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == {REG_PAGE_SIZE, 2'b00}) begin
                    side_reg = i_pwdata[COORD_BITS-1:0];
                end else if (i_paddr == {REG_MAX_PAGES, 2'b00}) begin
                    limit_reg = i_pwdata[LIMIT_BITS-1:0];
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want = pack_rect(int'(i_rect_width), int'(i_rect_height));
                placements_due = {placements_due, want};
            end
            if (i_out_valid && !i_out_stall) begin
                if (placements_due.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    errs++;
                end else begin
                    want = placements_due.pop_front();
                    if (i_placed !== want.placed) begin
                        $error("placed: expected %0d, got %0d", want.placed, i_placed);
                        errs++;
                    end
                    if (i_page_number !== want.page_number) begin
                        $error("page_number: expected %0d, got %0d",
                               want.page_number, i_page_number);
                        errs++;
                    end
                    if (i_pos_x !== want.pos_x) begin
                        $error("pos_x: expected %0d, got %0d", want.pos_x, i_pos_x);
                        errs++;
                    end
                    if (i_pos_y !== want.pos_y) begin
                        $error("pos_y: expected %0d, got %0d", want.pos_y, i_pos_y);
                        errs++;
                    end
                end
            end
        end
        o_mismatches <= o_mismatches + errs;
        o_pending    <= placements_due.size();
    end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the shelf packer: clock, reset, requests, register writes and the verdict.
`timescale 1ns / 1ps
module tb
    import mpsp_pkg::*;
();

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 106;
    localparam int PHASE_SIDE      [8] = '{128, 256, 512, 1024, 2048, 4096, 8191, 1000};
    localparam int PHASE_LIMIT     [8] = '{3, 0, 5, 15, 9, 8, 12, 1};
    localparam int PHASE_IDLE_PCT  [8] = '{0, 88, 0, 19, 0, 88, 0, 19};
    localparam int PHASE_STALL_PCT [8] = '{0, 0, 88, 19, 0, 0, 88, 19};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [COORD_BITS-1:0] rect_w = '0;
    logic [COORD_BITS-1:0] rect_h = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  placed;
    logic [PNUM_BITS-1:0]  page_number;
    logic [POS_BITS-1:0]   pos_x;
    logic [POS_BITS-1:0]   pos_y;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [2:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    int                    pending;
    int                    mismatches;
    int                    idle_pct = 0;
    int                    stall_pct = 0;
    logic                  hold_req = 1'b0;
    logic                  hold_done = 1'b0;
    int                    hold_count = 0;
    int                    cycle_count = 0;

    multi_page_shelf_packer dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_rect_width  (rect_w),
        .i_rect_height (rect_h),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_placed      (placed),
        .o_page_number (page_number),
        .o_pos_x       (pos_x),
        .o_pos_y       (pos_y),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    placement_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_rect_width  (rect_w),
        .i_rect_height (rect_h),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_placed      (placed),
        .i_page_number (page_number),
        .i_pos_x       (pos_x),
        .i_pos_y       (pos_y),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_pending     (pending),
        .o_mismatches  (mismatches)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // The receiver stalls at random, and once holds off long enough for the block to back up.
    always @(posedge clk) begin
        if (hold_req && !hold_done) begin
            out_stall  <= 1'b1;
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_CYCLES - 1) begin
                hold_done <= 1'b1;
            end
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic offer_rect(input int w, input int h);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rect_w   <= COORD_BITS'(w);
        rect_h   <= COORD_BITS'(h);
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input int value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        // The checker's pending count is registered and lags the result transfers.
        repeat (16) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic int rand_dim(input int side);
        int pick;
        pick = $urandom_range(99);
        if (pick < 65) return $urandom_range(side / 6);
        if (pick < 80) return $urandom_range(side - 2, side / 6);
        if (pick < 90) return side - $urandom_range(4, 1);
        return $urandom_range(int'(COORD_MAX));
    endfunction

    initial begin
        int side;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_rect(1, 1);
        offer_rect(0, 0);
        offer_rect(1022, 1);
        offer_rect(1023, 1);
        offer_rect(1, 1023);
        offer_rect(8191, 8191);
        offer_rect(4096, 1);
        offer_rect(0, 1022);
        write_reg(REG_MAX_PAGES, 1);
        offer_rect(1022, 1022);
        write_reg(REG_MAX_PAGES, 0);
        offer_rect(1022, 1022);
        offer_rect(2, 2);
        write_reg(REG_PAGE_SIZE, 63);
        write_reg(REG_MAX_PAGES, 8);
        offer_rect(62, 62);
        offer_rect(63, 1);
        offer_rect(0, 0);
        write_reg(REG_PAGE_SIZE, 0);
        offer_rect(62, 0);
        write_reg(REG_PAGE_SIZE, 64);
        offer_rect(5, 5);
        write_reg(REG_PAGE_SIZE, 8191);
        write_reg(REG_MAX_PAGES, 15);
        offer_rect(4094, 4094);
        offer_rect(4095, 1);
        offer_rect(1, 4095);
        offer_rect(4094, 1);
        write_reg(REG_PAGE_SIZE, 4096);
        offer_rect(4096, 4096);

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_PAGE_SIZE, PHASE_SIDE[ph]);
            write_reg(REG_MAX_PAGES, PHASE_LIMIT[ph]);
            side = PHASE_SIDE[ph];
            if (side < int'(MIN_PAGE)) side = int'(MIN_PAGE);
            if (side > int'(MAX_PAGE)) side = int'(MAX_PAGE);
            idle_pct  = PHASE_IDLE_PCT[ph];
            stall_pct <= PHASE_STALL_PCT[ph];
            if (ph == 4) begin
                hold_req <= 1'b1;
            end
            repeat (PHASE_ITEMS) offer_rect(rand_dim(side), rand_dim(side));
        end

        in_valid  <= 1'b0;
        stall_pct <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/mpsp_pkg.sv
hdl/mpsp_page_mem.sv
hdl/mpsp_fit.sv
hdl/multi_page_shelf_packer.sv
tb/placement_checker.sv
tb/tb.sv
